>>> design/swpbe_pkg.sv
package swpbe_pkg;

    localparam int DATA_W = 8;
    localparam int DUR_W  = 8;
    localparam int IDX_W  = 2;
    localparam int BIT_CNT_W = $clog2(DATA_W);

    // Register indexes on the configuration port
    localparam logic [IDX_W-1:0] REG_PULSE     = 2'd0;
    localparam logic [IDX_W-1:0] REG_ZERO_WAIT = 2'd1;
    localparam logic [IDX_W-1:0] REG_ONE_WAIT  = 2'd2;

    // Reset values of the timing registers
    localparam logic [DUR_W-1:0] RESET_PULSE     = 8'd1;
    localparam logic [DUR_W-1:0] RESET_ZERO_WAIT = 8'd4;
    localparam logic [DUR_W-1:0] RESET_ONE_WAIT  = 8'd1;

    localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(DATA_W - 1);

    typedef struct packed {
        logic [DUR_W-1:0] pulse_units;
        logic [DUR_W-1:0] zero_wait_units;
        logic [DUR_W-1:0] one_wait_units;
    } timing_t;

endpackage

>>> design/swpbe_if.sv
interface swpbe_byte_if
    import swpbe_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              send_sync;

    modport source (output valid, output data_byte, output send_sync, input ready);
    modport sink (input valid, input data_byte, input send_sync, output ready);
endinterface

interface swpbe_seg_if
    import swpbe_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             line_level;
    logic [DUR_W-1:0] duration_units;
    logic             last_segment;

    modport source (
        output valid, output line_level, output duration_units, output last_segment,
        input ready
    );
    modport sink (
        input valid, input line_level, input duration_units, input last_segment,
        output ready
    );
endinterface

interface swpbe_cfg_if
    import swpbe_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  reg_index;
    logic [DUR_W-1:0]  wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

>>> design/swpbe_regs.sv
module swpbe_regs
    import swpbe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    swpbe_cfg_if.sink  cfg,
    output timing_t    timing
);

    timing_t timing_reg;
    timing_t timing_next;

    assign cfg.ready = 1'b1;
    assign timing    = timing_reg;

    // Decode the write word; unknown indexes drop the write
    always_comb
    begin
        timing_next = timing_reg;
        if (cfg.valid)
        begin
            case (cfg.reg_index)
                REG_PULSE:     timing_next.pulse_units     = cfg.wr_data;
                REG_ZERO_WAIT: timing_next.zero_wait_units = cfg.wr_data;
                REG_ONE_WAIT:  timing_next.one_wait_units  = cfg.wr_data;
                default:       timing_next = timing_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg.pulse_units     <= RESET_PULSE;
            timing_reg.zero_wait_units <= RESET_ZERO_WAIT;
            timing_reg.one_wait_units  <= RESET_ONE_WAIT;
        end
        else
        begin
            timing_reg <= timing_next;
        end
    end

endmodule

>>> design/swpbe_seq.sv
module swpbe_seq
    import swpbe_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  timing_t      timing,
    swpbe_byte_if.sink   item_in,
    swpbe_seg_if.source  seg_out
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SYNC_HI,
        ST_SYNC_LO,
        ST_SYNC_WAIT,
        ST_BIT_HI,
        ST_BIT_LO,
        ST_BIT_HI2,
        ST_BIT_WAIT
    } state_t;

    state_t                state_reg, state_next;
    logic [DATA_W-1:0]     shift_reg, shift_next;
    logic [BIT_CNT_W-1:0]  bit_cnt_reg, bit_cnt_next;
    logic                  valid_reg, valid_next;
    logic                  level_reg, level_next;
    logic [DUR_W-1:0]      dur_reg, dur_next;
    logic                  last_reg, last_next;

    logic                  emit;
    logic                  cur_bit;

    assign item_in.ready = (state_reg == ST_IDLE);
    assign seg_out.valid          = valid_reg;
    assign seg_out.line_level     = level_reg;
    assign seg_out.duration_units = dur_reg;
    assign seg_out.last_segment   = last_reg;

    // Output register frees up when empty or taken this cycle
    assign emit    = (state_reg != ST_IDLE) && (!valid_reg || seg_out.ready);
    assign cur_bit = shift_reg[DATA_W-1];

    // Walk the segment sequence, one segment per emit
    always_comb
    begin
        state_next   = state_reg;
        shift_next   = shift_reg;
        bit_cnt_next = bit_cnt_reg;
        valid_next   = valid_reg && !seg_out.ready;
        level_next   = level_reg;
        dur_next     = dur_reg;
        last_next    = last_reg;

        if (state_reg == ST_IDLE)
        begin
            if (item_in.valid)
            begin
                shift_next   = item_in.data_byte;
                bit_cnt_next = '0;
                state_next   = item_in.send_sync ? ST_SYNC_HI : ST_BIT_HI;
            end
        end
        else if (emit)
        begin
            valid_next = 1'b1;
            last_next  = 1'b0;
            case (state_reg)
                ST_SYNC_HI:
                begin
                    level_next = 1'b1;
                    dur_next   = timing.pulse_units;
                    state_next = ST_SYNC_LO;
                end
                ST_SYNC_LO:
                begin
                    level_next = 1'b0;
                    dur_next   = timing.pulse_units;
                    state_next = ST_SYNC_WAIT;
                end
                ST_SYNC_WAIT:
                begin
                    level_next = 1'b0;
                    dur_next   = timing.zero_wait_units;
                    state_next = ST_BIT_HI;
                end
                ST_BIT_HI:
                begin
                    level_next = 1'b1;
                    dur_next   = timing.pulse_units;
                    state_next = ST_BIT_LO;
                end
                ST_BIT_LO:
                begin
                    level_next = 1'b0;
                    dur_next   = timing.pulse_units;
                    state_next = cur_bit ? ST_BIT_HI2 : ST_BIT_WAIT;
                end
                ST_BIT_HI2:
                begin
                    level_next = 1'b1;
                    dur_next   = timing.pulse_units;
                    state_next = ST_BIT_WAIT;
                end
                ST_BIT_WAIT:
                begin
                    level_next = 1'b0;
                    dur_next   = cur_bit ? timing.one_wait_units : timing.zero_wait_units;
                    last_next  = (bit_cnt_reg == LAST_BIT);
                    // Advance to the next bit, or drop back to idle after the last
                    if (bit_cnt_reg == LAST_BIT)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        shift_next   = {shift_reg[DATA_W-2:0], 1'b0};
                        bit_cnt_next = bit_cnt_reg + 1'b1;
                        state_next   = ST_BIT_HI;
                    end
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    // Hold state, shift data and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            valid_reg   <= 1'b0;
            bit_cnt_reg <= '0;
            shift_reg   <= '0;
            level_reg   <= 1'b0;
            dur_reg     <= '0;
            last_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            bit_cnt_reg <= bit_cnt_next;
            shift_reg   <= shift_next;
            level_reg   <= level_next;
            dur_reg     <= dur_next;
            last_reg    <= last_next;
        end
    end

endmodule

>>> design/single_wire_pulse_bit_encoder.sv
// Single-wire pulse bit encoder. Each accepted byte (with an optional cycle-time
// sync in front) becomes a run of line segments, each a wire level and a length
// in time units, sent MSB first: every bit opens with a high pulse and a low
// gap, a one bit adds a second high pulse and the one-bit wait, a zero bit adds
// the zero-bit wait. A byte yields 24 to 32 segments, plus 3 with sync; the last
// one carries last_segment. A segment sequencer hands out one segment per clock
// through a single output register while the sink does not stall, and input
// ready stays low until the last segment has been loaded into the output
// register. Timing registers (pulse, zero wait, one wait; reset 1, 4, 1) are
// written through the configuration port, which is always ready; write them
// only while no byte is in flight.
module single_wire_pulse_bit_encoder
    import swpbe_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    swpbe_byte_if.sink   item_in,
    swpbe_seg_if.source  seg_out,
    swpbe_cfg_if.sink    cfg
);

    timing_t timing;

    // Timing registers
    swpbe_regs u_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .timing (timing)
    );

    // Segment sequencer and output register
    swpbe_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .timing  (timing),
        .item_in (item_in),
        .seg_out (seg_out)
    );

endmodule

>>> test/single_wire_pulse_bit_encoder_tb.sv
module single_wire_pulse_bit_encoder_tb;
    import swpbe_pkg::*;

    // Index past the last timing register; writes to it must be dropped
    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic             line_level;
        logic [DUR_W-1:0] duration_units;
        logic             last_segment;
    } segment_t;

    // Tracks the timing registers and the line segments still owed by the encoder
    class segment_tracker;
        logic [DUR_W-1:0] pulse_units;
        logic [DUR_W-1:0] zero_wait_units;
        logic [DUR_W-1:0] one_wait_units;
        segment_t         expected_segments[$];
        int               failures;

        function new();
            pulse_units     = RESET_PULSE;
            zero_wait_units = RESET_ZERO_WAIT;
            one_wait_units  = RESET_ONE_WAIT;
            failures        = 0;
        endfunction

        function void set_register(logic [IDX_W-1:0] idx, logic [DUR_W-1:0] value);
            case (idx)
                REG_PULSE:     pulse_units     = value;
                REG_ZERO_WAIT: zero_wait_units = value;
                REG_ONE_WAIT:  one_wait_units  = value;
                default:       ;
            endcase
        endfunction

        function void add_segment(logic level, logic [DUR_W-1:0] dur);
            segment_t seg;
            seg.line_level     = level;
            seg.duration_units = dur;
            seg.last_segment   = 1'b0;
            expected_segments.push_back(seg);
        endfunction

        // Expand one accepted word into its sync and bit segments, MSB first
        function void note_byte(logic [DATA_W-1:0] data_byte, logic send_sync);
            if (send_sync)
            begin
                add_segment(1'b1, pulse_units);
                add_segment(1'b0, pulse_units);
                add_segment(1'b0, zero_wait_units);
            end
            for (int b = DATA_W - 1; b >= 0; b--)
            begin
                add_segment(1'b1, pulse_units);
                add_segment(1'b0, pulse_units);
                if (data_byte[b])
                begin
                    add_segment(1'b1, pulse_units);
                    add_segment(1'b0, one_wait_units);
                end
                else
                begin
                    add_segment(1'b0, zero_wait_units);
                end
            end
            expected_segments[$].last_segment = 1'b1;
        endfunction

        function void check_segment(logic level, logic [DUR_W-1:0] dur, logic last);
            segment_t want;
            if (expected_segments.size() == 0)
            begin
                $display("%0t: unexpected segment level %0b duration %0d last %0b",
                         $time, level, dur, last);
                failures++;
                return;
            end
            want = expected_segments.pop_front();
            if (level !== want.line_level)
            begin
                $display("%0t: line_level expected %0b got %0b",
                         $time, want.line_level, level);
                failures++;
            end
            if (dur !== want.duration_units)
            begin
                $display("%0t: duration_units expected %0d got %0d",
                         $time, want.duration_units, dur);
                failures++;
            end
            if (last !== want.last_segment)
            begin
                $display("%0t: last_segment expected %0b got %0b",
                         $time, want.last_segment, last);
                failures++;
            end
        endfunction

        function int pending();
            return expected_segments.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   stall_pct;

    segment_tracker tracker;

    swpbe_byte_if byte_ch();
    swpbe_seg_if  seg_ch();
    swpbe_cfg_if  cfg_ch();

    single_wire_pulse_bit_encoder u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item_in (byte_ch),
        .seg_out (seg_ch),
        .cfg     (cfg_ch)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Check each accepted segment, then pick ready for the next cycle
    always @(posedge clk)
    begin
        if (seg_ch.valid === 1'b1 && seg_ch.ready === 1'b1)
            tracker.check_segment(seg_ch.line_level, seg_ch.duration_units,
                                  seg_ch.last_segment);
        seg_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Offer one word, idling first at the phase rate; valid stays high afterward
    task automatic send_byte(input logic [DATA_W-1:0] data_byte, input logic send_sync);
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_ch.valid     <= 1'b0;
            byte_ch.data_byte <= DATA_W'($urandom);
            byte_ch.send_sync <= 1'($urandom);
            @(posedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= data_byte;
        byte_ch.send_sync <= send_sync;
        do
            @(posedge clk);
        while (byte_ch.ready !== 1'b1);
        tracker.note_byte(data_byte, send_sync);
    endtask

    task automatic byte_release();
        byte_ch.valid <= 1'b0;
    endtask

    // Write one register; valid stays high for a following write
    task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [DUR_W-1:0] value);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wr_data   <= value;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        tracker.set_register(idx, value);
    endtask

    task automatic cfg_release();
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_timing(input logic [DUR_W-1:0] pulse, input logic [DUR_W-1:0] zero_w,
                              input logic [DUR_W-1:0] one_w);
        cfg_write(REG_PULSE, pulse);
        cfg_write(REG_ZERO_WAIT, zero_w);
        cfg_write(REG_ONE_WAIT, one_w);
        cfg_release();
    endtask

    // Hold until every owed segment has come out
    task automatic drain();
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [DUR_W-1:0] pick_units();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 8'd1;
        else if (r == 1)
            return 8'd255;
        else if (r == 2 && $urandom_range(3) == 0)
            return 8'd0;
        return DUR_W'($urandom_range(255, 1));
    endfunction

    initial
    begin
        tracker = new();
        send_idle_pct = 0;
        stall_pct     = 0;

        rst_n             <= 1'b0;
        byte_ch.valid     <= 1'b0;
        byte_ch.data_byte <= '0;
        byte_ch.send_sync <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.reg_index  <= REG_PULSE;
        cfg_ch.wr_data    <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset timing: byte extremes, single set bits, alternating patterns
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        byte_release();
        drain();

        // Zero timing values, then a write to the unused index that must not land
        set_timing(8'd0, 8'd0, 8'd0);
        cfg_write(REG_UNUSED, 8'hA5);
        cfg_release();
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        byte_release();
        drain();

        // Largest timing values
        set_timing(8'd255, 8'd255, 8'd255);
        send_byte(8'hC3, 1'b1);
        send_byte(8'h3C, 1'b0);
        byte_release();
        drain();

        // Mixed extremes so the three registers are told apart
        set_timing(8'd1, 8'd255, 8'd128);
        send_byte(8'h96, 1'b1);
        send_byte(8'h69, 1'b0);
        byte_release();
        drain();

        // Random words under random timing, cycling through the idling modes
        for (int phase = 0; phase < 8; phase++)
        begin
            set_timing(pick_units(), pick_units(), pick_units());
            if ($urandom_range(2) == 0)
            begin
                cfg_write(REG_UNUSED, DUR_W'($urandom));
                cfg_release();
            end
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 76; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 76; end
                default: begin send_idle_pct = 32; stall_pct = 32; end
            endcase
            for (int n = 0; n < 32; n++)
                send_byte(DATA_W'($urandom_range(255)), 1'($urandom_range(1)));
            byte_release();
            drain();
        end

        // Let any stray segment show up before the verdict
        repeat (40) @(posedge clk);
        if (tracker.failures == 0 && tracker.pending() == 0)
            $display("single_wire_pulse_bit_encoder_tb OK");
        else
            $display("single_wire_pulse_bit_encoder_tb NOT OK");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("single_wire_pulse_bit_encoder_tb NOT OK");
        $finish;
    end

endmodule

>>> sim.f
design/swpbe_pkg.sv
design/swpbe_if.sv
design/swpbe_regs.sv
design/swpbe_seq.sv
design/single_wire_pulse_bit_encoder.sv
test/single_wire_pulse_bit_encoder_tb.sv
